[rtl/sab_pkg.sv]
package sab_pkg;

  // Largest span side; wider register values saturate to it
  localparam int MAX_SIDE = 4096;

  // Counter and span width (fixed by the register widths)
  localparam int CNT_W = 13;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [2:0] REG_SCREEN_WIDTH   = 3'd0;
  localparam logic [2:0] REG_POS_X          = 3'd1;
  localparam logic [2:0] REG_POS_Y          = 3'd2;
  localparam logic [2:0] REG_TEXTURE_WIDTH  = 3'd3;
  localparam logic [2:0] REG_TEXTURE_HEIGHT = 3'd4;
  localparam logic [2:0] REG_FRAME_WIDTH    = 3'd5;
  localparam logic [2:0] REG_ANIM_FRAME     = 3'd6;
  localparam logic [2:0] REG_BLEND_MODE     = 3'd7;

  // Blend modes
  localparam logic [1:0] MODE_COPY = 2'd0;

  // Pixel classes decided by the front
  localparam logic [1:0] CLS_COPY  = 2'd0;
  localparam logic [1:0] CLS_KEEP  = 2'd1;
  localparam logic [1:0] CLS_BLEND = 2'd2;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [12:0] texture_width;
    logic [12:0] texture_height;
    logic [12:0] frame_width;
    logic [11:0] anim_frame;
    logic [1:0]  blend_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  // One classified item on its way from front to back
  typedef struct packed {
    pixel_t           src;
    pixel_t           dst;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             last;
    logic [1:0]       cls;
  } item_t;

  // Saturate a span side to MAX_SIDE
  function automatic logic [CNT_W-1:0] sat_side(input logic [CNT_W-1:0] v);
    if (int'(v) > MAX_SIDE) begin
      return CNT_W'(MAX_SIDE);
    end
    return v;
  endfunction

  // Exact floor(x/255) for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + 16'(x[15:8]) + 16'd1;
    return t[15:8];
  endfunction

endpackage

[rtl/sab_if.sv]
interface sab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_red;
  logic [7:0] src_green;
  logic [7:0] src_blue;
  logic [7:0] src_alpha;
  logic [7:0] dst_red;
  logic [7:0] dst_green;
  logic [7:0] dst_blue;
  logic [7:0] dst_alpha;

  modport source (output valid, output src_red, output src_green, output src_blue,
                  output src_alpha, output dst_red, output dst_green, output dst_blue,
                  output dst_alpha, input ready);
  modport sink (input valid, input src_red, input src_green, input src_blue,
                input src_alpha, input dst_red, input dst_green, input dst_blue,
                input dst_alpha, output ready);
endinterface

interface sab_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        write_enable;
  logic [23:0] screen_index;
  logic [23:0] texture_index;
  logic        last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_alpha, output write_enable, output screen_index,
                  output texture_index, output last, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_alpha, input write_enable, input screen_index,
                input texture_index, input last, output ready);
endinterface

[rtl/sprite_alpha_blit_unit.sv]
// Channel   Dir  Handshake      Payload
// pixels    in   valid/ready    src_red/green/blue/alpha, dst_red/green/blue/alpha
// results   out  valid/ready    out_red/green/blue/alpha, write_enable,
//                               screen_index, texture_index, last
// cfg       in   cfg_write      cfg_index (3b), cfg_data (13b), no read-back
//
// One item per cycle sustained while results.ready is high; an accepted item passes
// through the queue, the multiply stage and the output register.
// The front accepts whenever the 4-entry queue has room, even while a result waits.
// Items over an empty span are accepted and dropped without a result.
// Sync active-high reset clears counters, queue, stage valids; loads cfg defaults.
module sprite_alpha_blit_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  sab_in_if.sink      pixels,
  sab_out_if.source   results
);

  sab_pkg::cfg_t  cfg;
  sab_pkg::item_t push_item;
  sab_pkg::item_t pop_item;
  logic           push;
  logic           full;
  logic           pop;
  logic           pop_valid;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width   <= 13'd640;
      cfg.pos_x          <= '0;
      cfg.pos_y          <= '0;
      cfg.texture_width  <= '0;
      cfg.texture_height <= '0;
      cfg.frame_width    <= '0;
      cfg.anim_frame     <= '0;
      cfg.blend_mode     <= sab_pkg::MODE_COPY;
    end else if (cfg_write) begin
      case (cfg_index)
        sab_pkg::REG_SCREEN_WIDTH:   cfg.screen_width   <= cfg_data;
        sab_pkg::REG_POS_X:          cfg.pos_x          <= cfg_data[11:0];
        sab_pkg::REG_POS_Y:          cfg.pos_y          <= cfg_data[11:0];
        sab_pkg::REG_TEXTURE_WIDTH:  cfg.texture_width  <= cfg_data;
        sab_pkg::REG_TEXTURE_HEIGHT: cfg.texture_height <= cfg_data;
        sab_pkg::REG_FRAME_WIDTH:    cfg.frame_width    <= cfg_data;
        sab_pkg::REG_ANIM_FRAME:     cfg.anim_frame     <= cfg_data[11:0];
        sab_pkg::REG_BLEND_MODE:     cfg.blend_mode     <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  sab_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pixels    (pixels),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  sab_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  sab_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .results   (results)
  );

endmodule

[rtl/sab_front.sv]
module sab_front (
  input  logic              clk,
  input  logic              rst,
  input  sab_pkg::cfg_t     cfg,
  sab_in_if.sink            pixels,
  input  logic              full,
  output logic              push,
  output sab_pkg::item_t    push_item
);

  logic [sab_pkg::CNT_W-1:0] column_count;
  logic [sab_pkg::CNT_W-1:0] row_count;
  logic [sab_pkg::CNT_W-1:0] column_count_next;
  logic [sab_pkg::CNT_W-1:0] row_count_next;
  logic [sab_pkg::CNT_W-1:0] span_w;
  logic [sab_pkg::CNT_W-1:0] span_h;
  logic                      span_empty;
  logic                      accept;
  logic                      row_end;
  logic                      sprite_end;
  logic                      blending;

  // Span size for the current mode
  always_comb begin
    span_w = sab_pkg::sat_side(cfg.blend_mode[1] ? cfg.frame_width : cfg.texture_width);
    span_h = sab_pkg::sat_side(cfg.texture_height);
  end

  assign span_empty    = (span_w == '0) || (span_h == '0);
  assign pixels.ready  = !full;
  assign accept        = pixels.valid && !full;
  // Drop items over an empty span
  assign push          = accept && !span_empty;

  assign row_end    = column_count >= (span_w - 1'b1);
  assign sprite_end = row_end && (row_count >= (span_h - 1'b1));
  assign blending   = cfg.blend_mode != sab_pkg::MODE_COPY;

  // Classify the item and tag it with its position
  always_comb begin
    push_item.src.red   = pixels.src_red;
    push_item.src.green = pixels.src_green;
    push_item.src.blue  = pixels.src_blue;
    push_item.src.alpha = pixels.src_alpha;
    push_item.dst.red   = pixels.dst_red;
    push_item.dst.green = pixels.dst_green;
    push_item.dst.blue  = pixels.dst_blue;
    push_item.dst.alpha = pixels.dst_alpha;
    push_item.row       = row_count;
    push_item.col       = column_count;
    push_item.last      = sprite_end;
    if (!blending || pixels.src_alpha == 8'd255) begin
      push_item.cls = sab_pkg::CLS_COPY;
    end else if (pixels.src_alpha == 8'd0) begin
      push_item.cls = sab_pkg::CLS_KEEP;
    end else begin
      push_item.cls = sab_pkg::CLS_BLEND;
    end
  end

  // Advance the raster position
  always_comb begin
    if (sprite_end) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (row_end) begin
      column_count_next = '0;
      row_count_next    = row_count + 1'b1;
    end else begin
      column_count_next = column_count + 1'b1;
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (push) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

[rtl/sab_queue.sv]
module sab_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sab_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output sab_pkg::item_t pop_item
);

  localparam int PTR_W = $clog2(sab_pkg::QUEUE_DEPTH);
  localparam int FILL_W = $clog2(sab_pkg::QUEUE_DEPTH + 1);

  sab_pkg::item_t    entries [sab_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_pop;

  assign full      = fill == FILL_W'(sab_pkg::QUEUE_DEPTH);
  assign pop_valid = fill != '0;
  assign pop_item  = entries[rd_ptr];
  assign do_pop    = pop && pop_valid;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(sab_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(sab_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[rtl/sab_back.sv]
module sab_back (
  input  logic           clk,
  input  logic           rst,
  input  sab_pkg::cfg_t  cfg,
  input  logic           pop_valid,
  input  sab_pkg::item_t pop_item,
  output logic           pop,
  sab_out_if.source      results
);

  // Multiply stage
  logic                      a_valid;
  logic [1:0]                a_cls;
  logic                      a_last;
  sab_pkg::pixel_t           a_src;
  sab_pkg::pixel_t           a_dst;
  logic [15:0]               a_sum_red;
  logic [15:0]               a_sum_green;
  logic [15:0]               a_sum_blue;
  logic [23:0]               a_scr;
  logic [23:0]               a_tex;
  logic [23:0]               a_off;
  logic [sab_pkg::CNT_W-1:0] a_col;

  logic        b_valid;
  logic        en_a;
  logic        en_b;
  logic [7:0]  inv_alpha;
  logic [13:0] scr_row;
  logic [26:0] scr_prod;
  logic [25:0] tex_prod;
  logic [24:0] off_prod;

  // Advance each stage when the one after it has room
  assign en_b = !b_valid || results.ready;
  assign en_a = !a_valid || en_b;
  assign pop  = pop_valid && en_a;

  assign results.valid = b_valid;

  assign inv_alpha = 8'd255 - pop_item.src.alpha;
  assign scr_row   = 14'(cfg.pos_y) + 14'(pop_item.row);
  assign scr_prod  = 27'(scr_row) * 27'(cfg.screen_width);
  assign tex_prod  = 26'(pop_item.row) * 26'(cfg.texture_width);
  assign off_prod  = 25'(cfg.anim_frame) * 25'(cfg.frame_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid <= pop_valid;
      end
      if (en_b) begin
        b_valid <= a_valid;
      end
    end
  end

  // Form weighted sums and index products
  always_ff @(posedge clk) begin
    if (pop) begin
      a_cls       <= pop_item.cls;
      a_last      <= pop_item.last;
      a_src       <= pop_item.src;
      a_dst       <= pop_item.dst;
      a_col       <= pop_item.col;
      a_sum_red   <= 16'(pop_item.src.alpha) * 16'(pop_item.src.red)
                   + 16'(inv_alpha) * 16'(pop_item.dst.red);
      a_sum_green <= 16'(pop_item.src.alpha) * 16'(pop_item.src.green)
                   + 16'(inv_alpha) * 16'(pop_item.dst.green);
      a_sum_blue  <= 16'(pop_item.src.alpha) * 16'(pop_item.src.blue)
                   + 16'(inv_alpha) * 16'(pop_item.dst.blue);
      a_scr       <= scr_prod[23:0];
      a_tex       <= tex_prod[23:0];
      a_off       <= cfg.blend_mode[1] ? off_prod[23:0] : 24'd0;
    end
  end

  // Select the pixel and finish the indices
  always_ff @(posedge clk) begin
    if (en_b && a_valid) begin
      case (a_cls)
        sab_pkg::CLS_COPY: begin
          results.out_red   <= a_src.red;
          results.out_green <= a_src.green;
          results.out_blue  <= a_src.blue;
          results.out_alpha <= a_src.alpha;
        end
        sab_pkg::CLS_BLEND: begin
          results.out_red   <= sab_pkg::div255(a_sum_red);
          results.out_green <= sab_pkg::div255(a_sum_green);
          results.out_blue  <= sab_pkg::div255(a_sum_blue);
          results.out_alpha <= a_dst.alpha;
        end
        default: begin
          results.out_red   <= a_dst.red;
          results.out_green <= a_dst.green;
          results.out_blue  <= a_dst.blue;
          results.out_alpha <= a_dst.alpha;
        end
      endcase
      results.write_enable  <= a_cls != sab_pkg::CLS_KEEP;
      results.screen_index  <= a_scr + 24'(cfg.pos_x) + 24'(a_col);
      results.texture_index <= a_tex + 24'(a_col) + a_off;
      results.last          <= a_last;
    end
  end

endmodule
